// File: hdl/bpa_pkg.sv
// Shared types, codes and default sizes for the bitmap page allocator.
// Used by the controller, the datapath and the top level.

package bpa_pkg;

  localparam int DEF_NUM_PAGES = 65536;
  localparam int DEF_WORD_BITS = 64;

  localparam int OP_W   = 3;
  localparam int IDX_W  = 16;
  localparam int CNT_W  = 17;
  localparam int RES_W  = 16;
  localparam int STAT_W = 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC    = 3'd0,
    OP_FREE     = 3'd1,
    OP_RESERVE  = 3'd2,
    OP_RELEASE  = 3'd3,
    OP_ALL_USED = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    RS_DONE  = 2'd0,
    RS_NONE  = 2'd1,
    RS_RANGE = 2'd2
  } res_status_t;

  // Page window scanned by the datapath
  typedef enum logic [1:0] {
    SEG_UP    = 2'd0,  // hint up to the top page
    SEG_WRAP  = 2'd1,  // page 0 up to the hint
    SEG_RANGE = 2'd2,  // reserve / release range, clipped
    SEG_FREE  = 2'd3   // single page
  } seg_t;

  typedef enum logic [3:0] {
    S_CLR_RST,
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_LOAD,
    S_BASE,
    S_CHECK,
    S_RD,
    S_EV,
    S_CLR_OP,
    S_FIN
  } state_t;

  typedef struct packed {
    logic        in_load;
    logic        div_load;
    logic        seg_load;
    seg_t        seg_sel;
    logic        base_load;
    logic        ev;
    logic        advance;
    logic        clr_start;
    logic        clr_step;
    logic        res_set;
    res_status_t res_code;
    logic        out_load;
  } bpa_cmd_t;

  typedef struct packed {
    op_t  op;
    seg_t seg;
    logic idx_bad;
    logic cnt_zero;
    logic empty;
    logic seg_last;
    logic found;
    logic clr_last;
    logic out_full;
  } bpa_stat_t;

endpackage

// File: hdl/bpa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.

module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/bpa_ctrl.sv
// Request sequencer for the bitmap page allocator.
// Depends on bpa_pkg; drives the datapath through bpa_cmd_t.

module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  bpa_stat_t stat,
  output bpa_cmd_t  cmd
);

  state_t state, state_next;
  logic   is_alloc;

  assign is_alloc = (stat.op == OP_ALLOC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR_RST;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLR_RST: begin
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (stat.op)
          OP_ALLOC:    state_next = S_BASE;
          OP_FREE:     state_next = stat.idx_bad ? S_FIN : S_DIV;
          OP_RESERVE,
          OP_RELEASE:  state_next = (stat.cnt_zero || stat.idx_bad) ? S_FIN : S_DIV;
          OP_ALL_USED: state_next = S_CLR_OP;
          default:     state_next = S_FIN;
        endcase
      end
      S_DIV:  state_next = S_LOAD;
      S_LOAD: state_next = S_BASE;
      S_BASE: state_next = S_CHECK;
      S_CHECK: begin
        if (stat.empty) begin
          state_next = (is_alloc && stat.seg == SEG_UP) ? S_BASE : S_FIN;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: state_next = S_EV;
      S_EV: begin
        if (is_alloc && stat.found) begin
          state_next = S_FIN;
        end else if (stat.seg_last) begin
          state_next = (is_alloc && stat.seg == SEG_UP) ? S_BASE : S_FIN;
        end else begin
          state_next = S_RD;
        end
      end
      S_CLR_OP: begin
        if (stat.clr_last) state_next = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_full) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      S_CLR_RST: cmd.clr_step = 1'b1;
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.in_load = s_tvalid;
      end
      S_DECODE: begin
        case (stat.op)
          OP_ALLOC: begin
            cmd.seg_load = 1'b1;
            cmd.seg_sel  = SEG_UP;
          end
          OP_FREE: begin
            cmd.res_set  = stat.idx_bad;
            cmd.res_code = RS_RANGE;
          end
          OP_RESERVE,
          OP_RELEASE: begin
            cmd.res_set  = !stat.cnt_zero && stat.idx_bad;
            cmd.res_code = RS_RANGE;
          end
          OP_ALL_USED: cmd.clr_start = 1'b1;
          default: ;
        endcase
      end
      S_DIV: cmd.div_load = 1'b1;
      S_LOAD: begin
        cmd.seg_load = 1'b1;
        cmd.seg_sel  = (stat.op == OP_FREE) ? SEG_FREE : SEG_RANGE;
      end
      S_BASE: cmd.base_load = 1'b1;
      S_CHECK: begin
        if (stat.empty && is_alloc) begin
          if (stat.seg == SEG_UP) begin
            cmd.seg_load = 1'b1;
            cmd.seg_sel  = SEG_WRAP;
          end else begin
            cmd.res_set  = 1'b1;
            cmd.res_code = RS_NONE;
          end
        end
      end
      S_EV: begin
        cmd.ev = 1'b1;
        if (!(is_alloc && stat.found)) begin
          if (!stat.seg_last) begin
            cmd.advance = 1'b1;
          end else if (is_alloc) begin
            if (stat.seg == SEG_UP) begin
              cmd.seg_load = 1'b1;
              cmd.seg_sel  = SEG_WRAP;
            end else begin
              cmd.res_set  = 1'b1;
              cmd.res_code = RS_NONE;
            end
          end
        end
      end
      S_CLR_OP: cmd.clr_step = 1'b1;
      S_FIN: cmd.out_load = !stat.out_full;
      default: ;
    endcase
  end

endmodule

// File: hdl/bpa_dpath.sv
// Datapath: used-bit map in RAM, search hint, page window, word masks,
// first-free search and the output word register. Depends on bpa_pkg, bpa_ram.

module bpa_dpath
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES = DEF_NUM_PAGES,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [OP_W-1:0]         op_in,
  input  logic [IDX_W-1:0]        idx_in,
  input  logic [CNT_W-1:0]        cnt_in,
  input  bpa_cmd_t                cmd,
  output bpa_stat_t               stat,
  input  logic                    m_tready,
  output logic                    out_valid,
  output logic [RES_W-1:0]        out_page,
  output res_status_t             out_status
);

  localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int PG_W      = $clog2(NUM_PAGES + 1);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int REL_W     = BIT_W + 1;
  localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WD_W      = $clog2(MAP_WORDS + 1);
  localparam int SUM_W     = (PG_W > CNT_W + 1) ? PG_W : CNT_W + 1;
  localparam int MUL_W     = PG_W + WD_W;
  // page index / WORD_BITS as a multiply by a rounded-up reciprocal
  localparam int RSHIFT    = IDX_W + BIT_W;
  localparam int RC_W      = IDX_W + 2;
  localparam logic [RC_W-1:0] RECIP =
    RC_W'(((64'd1 << RSHIFT) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

  op_t               op;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  cnt;
  seg_t              seg;
  logic [PG_W-1:0]   lo, hi, base, hint;
  logic [WD_W-1:0]   word, hint_word, q;
  logic [WA_W-1:0]   clr_cnt;
  logic [RES_W-1:0]  res_page;
  res_status_t       res_status;

  logic [SUM_W-1:0]        idx_ext, end_sum, end_clip, idx_p1;
  logic [IDX_W+RC_W-1:0]   div_prod, div_sh;
  logic [MUL_W-1:0]        base_prod;
  logic [PG_W:0]           base_wb;
  logic [PG_W-1:0]         lo_diff, hi_diff, found_page, hint_inc;
  logic [REL_W-1:0]        lo_rel, hi_rel;
  logic [WORD_BITS-1:0]    mask, cand, iso;
  logic [BIT_W-1:0]        bidx;
  logic [WD_W-1:0]         hint_word_inc;
  logic [PG_W+RES_W-1:0]   page_pad;
  logic                    clr_last;

  logic                    wr_en;
  logic [WA_W-1:0]         wr_addr;
  logic [WORD_BITS-1:0]    wr_data, rd_data;

  // ---- request decode ----
  assign idx_ext  = SUM_W'(idx);
  assign end_sum  = idx_ext + SUM_W'(cnt);
  assign end_clip = (end_sum > SUM_W'(NUM_PAGES)) ? SUM_W'(NUM_PAGES) : end_sum;
  assign idx_p1   = idx_ext + SUM_W'(1);

  assign div_prod = {{RC_W{1'b0}}, idx} * {{IDX_W{1'b0}}, RECIP};
  assign div_sh   = div_prod >> RSHIFT;

  assign base_prod = MUL_W'(word) * MUL_W'(WORD_BITS);
  assign base_wb   = {1'b0, base} + (PG_W+1)'(WORD_BITS);

  // ---- word mask: pages in [lo, hi) that fall in the current word ----
  assign lo_diff = lo - base;
  assign hi_diff = hi - base;

  always_comb begin
    if (lo <= base) begin
      lo_rel = '0;
    end else if (lo_diff >= PG_W'(WORD_BITS)) begin
      lo_rel = REL_W'(WORD_BITS);
    end else begin
      lo_rel = lo_diff[REL_W-1:0];
    end
    if (hi <= base) begin
      hi_rel = '0;
    end else if (hi_diff >= PG_W'(WORD_BITS)) begin
      hi_rel = REL_W'(WORD_BITS);
    end else begin
      hi_rel = hi_diff[REL_W-1:0];
    end
  end

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      mask[j] = (REL_W'(j) >= lo_rel) && (REL_W'(j) < hi_rel);
    end
  end

  // ---- first free page in the masked word ----
  assign cand = ~rd_data & mask;
  assign iso  = cand & (~cand + WORD_BITS'(1));

  always_comb begin
    bidx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (iso[j]) bidx = bidx | BIT_W'(j);
    end
  end

  assign found_page    = base + PG_W'(bidx);
  assign hint_inc      = found_page + PG_W'(1);
  assign hint_word_inc = (bidx == BIT_W'(WORD_BITS - 1)) ? word + WD_W'(1) : word;
  assign page_pad      = {{RES_W{1'b0}}, found_page};
  assign clr_last      = (clr_cnt == WA_W'(MAP_WORDS - 1));

  // ---- map RAM port control ----
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = word[WA_W-1:0];
    wr_data = rd_data;
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '1;
    end else if (cmd.ev) begin
      case (op)
        OP_ALLOC: begin
          wr_en   = |cand;
          wr_data = rd_data | iso;
        end
        OP_RESERVE: begin
          wr_en   = 1'b1;
          wr_data = rd_data | mask;
        end
        OP_RELEASE,
        OP_FREE: begin
          wr_en   = 1'b1;
          wr_data = rd_data & ~mask;
        end
        default: ;
      endcase
    end
  end

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (WA_W)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (word[WA_W-1:0]),
    .rd_data (rd_data)
  );

  // ---- control state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      hint      <= '0;
      hint_word <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_start) begin
        hint      <= '0;
        hint_word <= '0;
        clr_cnt   <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt <= clr_last ? '0 : clr_cnt + WA_W'(1);
      end else if (cmd.ev) begin
        if (op == OP_ALLOC && (|cand)) begin
          hint      <= hint_inc;
          hint_word <= hint_word_inc;
        end else if (op == OP_FREE && lo < hint) begin
          hint      <= lo;
          hint_word <= word;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op         <= op_t'(op_in);
      idx        <= idx_in;
      cnt        <= cnt_in;
      res_page   <= '0;
      res_status <= RS_DONE;
    end else begin
      if (cmd.res_set) res_status <= cmd.res_code;
      if (cmd.ev && op == OP_ALLOC && (|cand)) res_page <= page_pad[RES_W-1:0];
    end
    if (cmd.div_load) q <= div_sh[WD_W-1:0];
    if (cmd.seg_load) begin
      seg <= cmd.seg_sel;
      case (cmd.seg_sel)
        SEG_UP: begin
          lo   <= hint;
          hi   <= PG_W'(NUM_PAGES);
          word <= hint_word;
        end
        SEG_WRAP: begin
          lo   <= '0;
          hi   <= hint;
          word <= '0;
        end
        SEG_RANGE: begin
          lo   <= idx_ext[PG_W-1:0];
          hi   <= end_clip[PG_W-1:0];
          word <= q;
        end
        default: begin
          lo   <= idx_ext[PG_W-1:0];
          hi   <= idx_p1[PG_W-1:0];
          word <= q;
        end
      endcase
    end else if (cmd.advance) begin
      word <= word + WD_W'(1);
      base <= base_wb[PG_W-1:0];
    end
    if (cmd.base_load) base <= base_prod[PG_W-1:0];
    if (cmd.out_load) begin
      out_page   <= res_page;
      out_status <= res_status;
    end
  end

  always_comb begin
    stat          = '0;
    stat.op       = op;
    stat.seg      = seg;
    stat.idx_bad  = (idx_ext >= SUM_W'(NUM_PAGES));
    stat.cnt_zero = (cnt == '0);
    stat.empty    = (lo >= hi);
    stat.seg_last = (base_wb >= {1'b0, hi});
    stat.found    = |cand;
    stat.clr_last = clr_last;
    stat.out_full = out_valid;
  end

endmodule

// File: hdl/bitmap_page_allocator.sv
// Bitmap page-frame allocator with a next-fit hint, top level.
// Depends on bpa_pkg, bpa_ctrl, bpa_dpath (which holds bpa_ram).
//
//  channel  | dir | width | contents
//  s_axis   | in  | 40    | op[2:0], page_index[18:3], page_count[35:19]
//  m_axis   | out | 24    | result_page[15:0], status[17:16]
//
// One request at a time. Free / range: each map word touched is read, then rewritten.
// Allocate: map words are scanned (up to MAP_WORDS+1 words), with a new base and check
// when the search wraps; each word passes through the S_RD and S_EV states for the RAM read.
// Reset and mark-all-used sweep the map RAM, one word a cycle (MAP_WORDS
// words, 1024 at the default size); no request is taken during the reset sweep.
// A finished word waits in the output register; m_tready low stalls the next finish.

module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES = DEF_NUM_PAGES,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // op[2:0], page_index[18:3], page_count[35:19]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // result_page[15:0], status[17:16]
);

  localparam int OUT_PAD_W = OUT_TDATA_W - RES_W - STAT_W;

  bpa_cmd_t    cmd;
  bpa_stat_t   stat;
  logic [RES_W-1:0] out_page;
  res_status_t out_status;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpa_dpath #(
    .NUM_PAGES (NUM_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .op_in      (s_tdata[OP_W-1:0]),
    .idx_in     (s_tdata[OP_W+IDX_W-1:OP_W]),
    .cnt_in     (s_tdata[OP_W+IDX_W+CNT_W-1:OP_W+IDX_W]),
    .cmd        (cmd),
    .stat       (stat),
    .m_tready   (m_tready),
    .out_valid  (m_tvalid),
    .out_page   (out_page),
    .out_status (out_status)
  );

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_status, out_page};

endmodule
